// File: hdl/fmt_pkg.sv
// Shared constants and the sine table builder for the FM test tone generator.
`timescale 1ns / 1ps
`default_nettype none

package fmt_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_RATE_HZ_DEF   = 48000;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int INDEX_BITS_DEF       = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CARRIER   = 2'd0,
        CFG_MOD       = 2'd1,
        CFG_DEVIATION = 2'd2
    } cfg_index_t;

    localparam logic [14:0] CARRIER_RESET   = 15'd1000;
    localparam logic [14:0] MOD_RESET       = 15'd100;
    localparam logic [6:0]  DEVIATION_RESET = 7'd10;

    // Modulation index: floor(fc*dev*2^16 / (200*fm)), Q8.16, saturating
    localparam int          BETA_NUM_W = 38;
    localparam int          BETA_DEN_W = 23;
    localparam int          BETA_W     = 24;
    localparam logic [7:0]  BETA_SCALE = 8'd200;
    localparam logic [23:0] BETA_MAX   = 24'hFF_FFFF;

    localparam logic [30:0] INV_PI_Q32 = 31'h517C_C1B7;
    localparam logic [14:0] FULL_SCALE = 15'h7FFF;

    localparam logic [63:0] HALF_PI_Q30 = 64'h6487_ED51;
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210, 64'd272};

    // One quarter-wave entry from a Q30 angle, integer Taylor series, Q0.15
    function automatic logic [14:0] sine_entry(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 8; k++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k & 1) == 1)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = '0;
        v = ((unsigned'(sum) << 15) + (64'd1 << 29)) >> 30;
        if (v > 64'(FULL_SCALE))
            v = 64'(FULL_SCALE);
        return v[14:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/fmt_beta_div.sv
// Iterative restoring divider that forms the saturated modulation index.
`timescale 1ns / 1ps
`default_nettype none

module fmt_beta_div
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [fmt_pkg::BETA_NUM_W-1:0]    num,
    input  wire logic [fmt_pkg::BETA_DEN_W-1:0]    den,
    output logic                                   busy,
    output logic [fmt_pkg::BETA_W-1:0]             beta
);

    localparam int NW = fmt_pkg::BETA_NUM_W;
    localparam int DW = fmt_pkg::BETA_DEN_W;
    localparam int QW = fmt_pkg::BETA_W;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] q_reg;
    logic          ovf_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        ge    = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg   <= {q_reg[QW-2:0], ge};
            // any bit pushed past the top means saturation
            ovf_reg <= ovf_reg | q_reg[QW-1];
        end
    end

    assign busy = busy_reg;
    assign beta = ovf_reg ? fmt_pkg::BETA_MAX : q_reg;

endmodule

`default_nettype wire

// File: hdl/fmt_turn_sine.sv
// Three-stage sine of a 32-bit turn fraction: fold, table read, interpolate.
`timescale 1ns / 1ps
`default_nettype none

module fmt_turn_sine
#(
    parameter int SINE_TABLE_DEPTH = fmt_pkg::SINE_TABLE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic [2:0]  adv,
    input  wire logic [31:0] phase,
    output logic [14:0]      mag,
    output logic             neg
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = 31 + AW;
    localparam logic [AW-1:0] DEPTH_W = AW'(SINE_TABLE_DEPTH);

    logic [14:0] rom [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [63:0] XG = (fmt_pkg::HALF_PI_Q30 * 64'(g)) / SINE_TABLE_DEPTH;
        assign rom[g] = fmt_pkg::sine_entry(XG);
    end

    // stage 1: fold into the first quadrant and scale to the table
    logic [30:0]   frac;
    logic [PW-1:0] pos;
    logic [AW-1:0] idx;
    logic [AW-1:0] ia_next;
    logic [AW-1:0] ib_next;
    logic [29:0]   rem_next;

    logic [AW-1:0] ia_reg;
    logic [AW-1:0] ib_reg;
    logic [29:0]   rem1_reg;
    logic          neg1_reg;

    always_comb
    begin
        frac = {1'b0, phase[29:0]};
        if (phase[30])
            frac = 31'h4000_0000 - frac;
        pos = PW'(frac) * PW'(DEPTH_W);
        idx = pos[30 +: AW];
        if (idx >= DEPTH_W)
        begin
            ia_next  = DEPTH_W;
            ib_next  = DEPTH_W;
            rem_next = '0;
        end
        else
        begin
            ia_next  = idx;
            ib_next  = idx + 1'b1;
            rem_next = pos[29:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ia_reg   <= ia_next;
            ib_reg   <= ib_next;
            rem1_reg <= rem_next;
            neg1_reg <= phase[31];
        end
    end

    // stage 2: registered table read at both neighbours
    logic [14:0] a_reg;
    logic [14:0] b_reg;
    logic [29:0] rem2_reg;
    logic        neg2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            a_reg    <= rom[ia_reg];
            b_reg    <= rom[ib_reg];
            rem2_reg <= rem1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // stage 3: linear interpolation, truncated
    logic [14:0] step;
    logic [44:0] prod;
    logic [14:0] mag_reg;
    logic        neg_reg;

    always_comb
    begin
        step = b_reg - a_reg;
        prod = 45'(step) * 45'(rem2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            mag_reg <= a_reg + prod[44:30];
            neg_reg <= neg2_reg;
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

`default_nettype wire

// File: hdl/fm_test_tone_generator.sv
// Top level: pipelined FM test tone generator with stream ports.
//
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata[15:0] sample_number
//  m_axis   | out       | tdata[15:0] left_sample, tdata[31:16] right_sample
//  cfg      | in        | cfg_index selects register, cfg_data[14:0] value
//
// One beat per clock through 16 register stages while m_axis_tready is high and the
// modulation index is ready (four of the stages form the phases by reciprocal multiplies).
// After reset and after every register write s_axis_tready stays low while the
// modulation index divider is started and then forms 38 quotient bits, one a cycle.
// Each stage holds its beat while the next one is full and held; empty stages close up.
`timescale 1ns / 1ps
`default_nettype none

module fm_test_tone_generator
#(
    parameter int SAMPLE_RATE_HZ   = fmt_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int SINE_TABLE_DEPTH = fmt_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int INDEX_BITS       = fmt_pkg::INDEX_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_number
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);

    localparam int ND = 4;
    localparam int SW = $clog2(SAMPLE_RATE_HZ);
    localparam int RW = SW + 1;
    localparam logic [RW-1:0] SR_W = RW'(SAMPLE_RATE_HZ);
    localparam logic [15:0] NMASK = (INDEX_BITS >= 16) ? 16'hFFFF
                                    : 16'((32'd1 << INDEX_BITS) - 1);

    // reciprocals of the rate: 2^31/rate for the turn count, 2^(32+SW)/rate for the fraction
    localparam int M1W = $clog2(((64'd1 << 31) / 64'(SAMPLE_RATE_HZ)) + 64'd1);
    localparam int M2W = $clog2(((64'd1 << (32 + SW)) / 64'(SAMPLE_RATE_HZ)) + 64'd1);
    localparam logic [M1W-1:0] RECIP1 = M1W'((64'd1 << 31) / 64'(SAMPLE_RATE_HZ));
    localparam logic [M2W-1:0] RECIP2 = M2W'((64'd1 << (32 + SW)) / 64'(SAMPLE_RATE_HZ));
    localparam int QPW = 31 + M1W;
    localparam int EPW = SW + M2W;

    localparam int ST_IN   = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_DIV0 = 2;
    localparam int ST_MSIN = ND + 2;
    localparam int ST_BM   = ND + 5;
    localparam int ST_OFF  = ND + 6;
    localparam int ST_PH   = ND + 7;
    localparam int ST_CSIN = ND + 8;
    localparam int ST_OUT  = ND + 11;
    localparam int NS      = ND + 12;

    // configuration and modulation index
    logic [14:0] carrier_reg;
    logic [14:0] mod_reg;
    logic [6:0]  dev_reg;
    logic        kick_reg;
    logic        cfg_hit;
    logic        beta_busy;
    logic        beta_ok;
    logic [fmt_pkg::BETA_W-1:0] beta;

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                fmt_pkg::CFG_CARRIER,
                fmt_pkg::CFG_MOD,
                fmt_pkg::CFG_DEVIATION: cfg_hit = 1'b1;
                default:                cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_reg <= fmt_pkg::CARRIER_RESET;
            mod_reg     <= fmt_pkg::MOD_RESET;
            dev_reg     <= fmt_pkg::DEVIATION_RESET;
            kick_reg    <= 1'b1;
        end
        else
        begin
            kick_reg <= cfg_hit;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    fmt_pkg::CFG_CARRIER:   carrier_reg <= cfg_data;
                    fmt_pkg::CFG_MOD:       mod_reg     <= cfg_data;
                    fmt_pkg::CFG_DEVIATION: dev_reg     <= cfg_data[6:0];
                    default:                ;
                endcase
            end
        end
    end

    logic [21:0] fc_dev;
    logic [fmt_pkg::BETA_DEN_W-1:0] beta_den;

    always_comb
    begin
        fc_dev   = 22'(carrier_reg) * 22'(dev_reg);
        beta_den = fmt_pkg::BETA_DEN_W'(fmt_pkg::BETA_SCALE) * fmt_pkg::BETA_DEN_W'(mod_reg);
    end

    fmt_beta_div u_beta_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (kick_reg),
        .num   ({fc_dev, 16'b0}),
        .den   (beta_den),
        .busy  (beta_busy),
        .beta  (beta)
    );

    assign beta_ok = !kick_reg && !beta_busy;

    // pipeline flow control
    logic [NS-1:0] vld_reg;
    logic [NS:0]   adv;

    always_comb
    begin
        adv[NS] = m_axis_tready;
        for (int i = NS - 1; i >= 0; i--)
            adv[i] = !vld_reg[i] || adv[i+1];
    end

    assign s_axis_tready = adv[ST_IN] && beta_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[ST_IN])
                vld_reg[ST_IN] <= s_axis_tvalid && beta_ok;
            for (int i = 1; i < NS; i++)
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // input and products f*n
    logic [15:0] n_reg;
    logic [30:0] prc_reg;
    logic [30:0] prm_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_IN])
            n_reg <= s_axis_tdata & NMASK;
        if (adv[ST_MUL])
        begin
            prc_reg <= 31'(carrier_reg) * 31'(n_reg);
            prm_reg <= 31'(mod_reg) * 31'(n_reg);
        end
    end

    // phase = floor((f*n mod rate) * 2^32 / rate); each reciprocal estimate is
    // at most one low and is put right by one compare
    logic [30:0]    xc_reg;
    logic [30:0]    xm_reg;
    logic [M1W-1:0] qc_reg;
    logic [M1W-1:0] qm_reg;
    logic [SW-1:0]  rc_reg;
    logic [SW-1:0]  rm_reg;
    logic [31:0]    ec_reg;
    logic [31:0]    em_reg;
    logic [31:0]    phc_reg;
    logic [31:0]    phm_reg;

    logic [QPW-1:0] qc_prod;
    logic [QPW-1:0] qm_prod;
    logic [RW-1:0]  tc;
    logic [RW-1:0]  tm;
    logic [SW-1:0]  rc_next;
    logic [SW-1:0]  rm_next;
    logic [EPW-1:0] ec_prod;
    logic [EPW-1:0] em_prod;
    logic [RW-1:0]  ecr;
    logic [RW-1:0]  emr;

    always_comb
    begin
        qc_prod = QPW'(prc_reg) * QPW'(RECIP1);
        qm_prod = QPW'(prm_reg) * QPW'(RECIP1);
        // remainder lies below twice the rate, so its low bits are enough
        tc      = xc_reg[RW-1:0] - RW'(qc_reg) * SR_W;
        tm      = xm_reg[RW-1:0] - RW'(qm_reg) * SR_W;
        rc_next = (tc >= SR_W) ? SW'(tc - SR_W) : SW'(tc);
        rm_next = (tm >= SR_W) ? SW'(tm - SR_W) : SW'(tm);
        ec_prod = EPW'(rc_reg) * EPW'(RECIP2);
        em_prod = EPW'(rm_reg) * EPW'(RECIP2);
        // r*2^32 has zero low bits, so the residue is minus the estimate times the rate
        ecr     = RW'(0) - ec_reg[RW-1:0] * SR_W;
        emr     = RW'(0) - em_reg[RW-1:0] * SR_W;
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_DIV0])
        begin
            xc_reg <= prc_reg;
            xm_reg <= prm_reg;
            qc_reg <= qc_prod[31 +: M1W];
            qm_reg <= qm_prod[31 +: M1W];
        end
        if (adv[ST_DIV0 + 1])
        begin
            rc_reg <= rc_next;
            rm_reg <= rm_next;
        end
        if (adv[ST_DIV0 + 2])
        begin
            ec_reg <= ec_prod[SW +: 32];
            em_reg <= em_prod[SW +: 32];
        end
        if (adv[ST_DIV0 + 3])
        begin
            phc_reg <= (ecr >= SR_W) ? (ec_reg + 32'd1) : ec_reg;
            phm_reg <= (emr >= SR_W) ? (em_reg + 32'd1) : em_reg;
        end
    end

    // modulating sine, carrier phase rides alongside
    logic [14:0] ms;
    logic        mneg;
    logic [31:0] pc1_reg;
    logic [31:0] pc2_reg;
    logic [31:0] pc3_reg;

    fmt_turn_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_mod_sine
    (
        .clk   (clk),
        .adv   (adv[ST_MSIN +: 3]),
        .phase (phm_reg),
        .mag   (ms),
        .neg   (mneg)
    );

    always_ff @(posedge clk)
    begin
        if (adv[ST_MSIN])
            pc1_reg <= phc_reg;
        if (adv[ST_MSIN + 1])
            pc2_reg <= pc1_reg;
        if (adv[ST_MSIN + 2])
            pc3_reg <= pc2_reg;
    end

    // phase offset = ((beta*|s|) >> 8) * floor(2^32/pi) >> 24
    logic [38:0] bm_prod;
    logic [61:0] off_prod;
    logic [30:0] bm_reg;
    logic [31:0] pc4_reg;
    logic        mneg4_reg;
    logic [31:0] off_reg;
    logic [31:0] pc5_reg;
    logic        mneg5_reg;
    logic [31:0] ph_reg;

    always_comb
    begin
        bm_prod  = 39'(beta) * 39'(ms);
        off_prod = 62'(bm_reg) * 62'(fmt_pkg::INV_PI_Q32);
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_BM])
        begin
            bm_reg    <= bm_prod[38:8];
            pc4_reg   <= pc3_reg;
            mneg4_reg <= mneg;
        end
        if (adv[ST_OFF])
        begin
            off_reg   <= off_prod[55:24];
            pc5_reg   <= pc4_reg;
            mneg5_reg <= mneg4_reg;
        end
        if (adv[ST_PH])
            ph_reg <= mneg5_reg ? (pc5_reg - off_reg) : (pc5_reg + off_reg);
    end

    // carrier sine and output scaling, truncated toward zero
    logic [14:0] cs;
    logic        cneg;
    logic [29:0] out_prod;
    logic [15:0] out_mag;
    logic [15:0] out_reg;

    fmt_turn_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_car_sine
    (
        .clk   (clk),
        .adv   (adv[ST_CSIN +: 3]),
        .phase (ph_reg),
        .mag   (cs),
        .neg   (cneg)
    );

    always_comb
    begin
        out_prod = 30'(cs) * 30'(fmt_pkg::FULL_SCALE);
        out_mag  = {1'b0, out_prod[29:15]};
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
            out_reg <= cneg ? (16'd0 - out_mag) : out_mag;
    end

    assign m_axis_tvalid = vld_reg[ST_OUT];
    assign m_axis_tdata  = {out_reg, out_reg};

`ifndef SYNTHESIS
    a_ready_needs_beta: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !beta_busy)
        else $error("input taken while modulation index is being computed");

    a_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (cfg_index == fmt_pkg::CFG_CARRIER || cfg_index == fmt_pkg::CFG_MOD
                       || cfg_index == fmt_pkg::CFG_DEVIATION)) |=> !s_axis_tready)
        else $error("input not held off after a register write");

    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] != 16'h8000))
        else $error("output sample outside symmetric range");
`endif

endmodule

`default_nettype wire

// File: bench/tb_fm_test_tone_generator.sv
// Self-checking bench for the FM test tone generator: random and directed beats.
`timescale 1ns / 1ps

module tb_fm_test_tone_generator;

    localparam int SR    = 48000;
    localparam int DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [14:0] cfg_data = '0;

    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 1'b0;

    always #10 clk = ~clk;

    fm_test_tone_generator u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got), $signed(want), $time);
        errors++;
    endtask

    class tone_scoreboard;
        logic [14:0] carrier;
        logic [14:0] modf;
        logic [6:0]  dev;
        int          quarter [DEPTH + 1];
        logic [15:0] pending [$];

        function void build();
            longint unsigned x, x2, term, v;
            longint          sum;
            for (int i = 0; i <= DEPTH; i++)
            begin
                x = (64'h6487ED51 * i) / DEPTH;
                x2 = (x * x) >> 30;
                term = x;
                sum = x;
                for (int k = 1; k <= 8; k++)
                begin
                    term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                    if (k & 1)
                        sum -= term;
                    else
                        sum += term;
                end
                if (sum < 0)
                    sum = 0;
                v = ((longint'(sum) << 15) + (64'd1 << 29)) >> 30;
                quarter[i] = (v > 32767) ? 32767 : int'(v);
            end
            carrier = 15'd1000;
            modf = 15'd100;
            dev = 7'd10;
        endfunction

        function int unsigned sine_mag(input logic [31:0] ph);
            longint unsigned frac, pos, idx, rem;
            frac = ph[29:0];
            if (ph[30])
                frac = (64'd1 << 30) - frac;
            pos = frac * DEPTH;
            idx = pos >> 30;
            rem = pos & ((64'd1 << 30) - 1);
            if (idx >= DEPTH)
                return quarter[DEPTH];
            return quarter[idx] + (((quarter[idx + 1] - quarter[idx]) * rem) >> 30);
        endfunction

        function logic [31:0] turn_phase(input longint unsigned f, input longint unsigned n);
            longint unsigned r;
            r = (f * n) % SR;
            return (r << 32) / SR;
        endfunction

        function void note_sample(input logic [15:0] n);
            longint unsigned beta, off, mag;
            logic [31:0]     pc, pm, ph;
            int              ms;
            if (modf == 0)
                beta = 24'hFFFFFF;
            else
            begin
                beta = ((longint'(carrier) * dev) << 16) / (200 * longint'(modf));
                if (beta > 24'hFFFFFF)
                    beta = 24'hFFFFFF;
            end
            pc = turn_phase(carrier, n);
            pm = turn_phase(modf, n);
            ms = sine_mag(pm);
            off = (((beta * ms) >> 8) * 64'h517CC1B7) >> 24;
            ph = pm[31] ? pc - off[31:0] : pc + off[31:0];
            mag = (longint'(sine_mag(ph)) * 32767) >> 15;
            pending.push_back(ph[31] ? -mag[15:0] : mag[15:0]);
        endfunction

        task check_sample(input logic [31:0] d);
            logic [15:0] want;
            if (pending.size() == 0)
            begin
                report("unexpected beat", d[15:0], 16'd0);
                return;
            end
            want = pending.pop_front();
            if (d[15:0] !== want)
                report("left_sample", d[15:0], want);
            if (d[31:16] !== want)
                report("right_sample", d[31:16], want);
        endtask
    endclass

    tone_scoreboard tone = new();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                tone.note_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                tone.check_sample(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || cfg_write)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired at %0t", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // tvalid stays high after the beat; an idle gap or drain() drops it
    task automatic send_sample(input logic [15:0] n);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        s_axis_tdata <= n;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tone.pending.size() != 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
    endtask

    // written only while idle; block re-runs its beta divider afterwards
    task automatic write_reg(input fmt_pkg::cfg_index_t idx, input logic [14:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        case (idx)
            fmt_pkg::CFG_CARRIER:   tone.carrier = val;
            fmt_pkg::CFG_MOD:       tone.modf = val;
            fmt_pkg::CFG_DEVIATION: tone.dev = val[6:0];
            default:                ;
        endcase
    endtask

    task automatic set_tone(input logic [14:0] fc, input logic [14:0] fm, input logic [14:0] dv);
        drain();
        write_reg(fmt_pkg::CFG_CARRIER, fc);
        write_reg(fmt_pkg::CFG_MOD, fm);
        write_reg(fmt_pkg::CFG_DEVIATION, dv);
    endtask

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
            send_sample(16'($urandom_range(16'hFFFF)));
    endtask

    initial
    begin
        tone.build();
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes at reset settings
        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'd12000);
        send_sample(16'd48000);
        // zero carrier, zero modulation frequency, max everything
        set_tone(15'd0, 15'd100, 15'd50);
        send_sample(16'd7);
        send_sample(16'd333);
        set_tone(15'd1000, 15'd0, 15'd10);
        send_sample(16'd5);
        send_sample(16'hFFFF);
        set_tone(15'h7FFF, 15'h7FFF, 15'h7F);
        send_sample(16'd1);
        send_sample(16'hAAAA);
        set_tone(15'd24000, 15'd1, 15'd100);
        send_sample(16'd3);
        send_sample(16'h5555);
        set_tone(15'd1, 15'd24000, 15'd0);
        send_sample(16'd9);
        send_sample(16'd24000);

        send_idle_pct = 26;
        recv_idle_pct = 47;
        set_tone(15'd1000, 15'd100, 15'd10);
        random_run(170);
        set_tone(15'($urandom_range(1, 24000)), 15'($urandom_range(1, 24000)),
                 15'($urandom_range(0, 100)));
        random_run(170);

        send_idle_pct = 47;
        recv_idle_pct = 26;
        set_tone(15'($urandom_range(1, 24000)), 15'($urandom_range(1, 200)),
                 15'($urandom_range(0, 100)));
        random_run(170);
        set_tone(15'($urandom_range(15'h7FFF)), 15'($urandom_range(15'h7FFF)),
                 15'($urandom_range(15'h7FFF)));
        random_run(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_tone(15'($urandom_range(1, 24000)), 15'($urandom_range(1, 24000)),
                 15'($urandom_range(0, 100)));
        // long receiver hold-off so the pipeline fills and backs up
        fork
            begin
                hold_off = 1'b1;
                repeat (200)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            random_run(100);
        join
        random_run(100);

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
